/* rtl/ugs_pkg.sv */
package ugs_pkg;

    // Number of vertex slots; sets the slot table and adjacency matrix size.
    localparam int MAX_VERTICES = 16;
    localparam int SLOT_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

    typedef logic [SLOT_W-1:0]       t_slot;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [MAX_VERTICES-1:0] t_row;
    typedef logic [31:0]             t_label;
    typedef logic [2:0]              t_op;
    typedef logic [1:0]              t_status;

    localparam t_cnt SLOT_COUNT = CNT_W'(MAX_VERTICES);

    // Request codes.
    localparam t_op OP_ADD_VERTEX    = 3'd0;
    localparam t_op OP_REMOVE_VERTEX = 3'd1;
    localparam t_op OP_ADD_EDGE      = 3'd2;
    localparam t_op OP_REMOVE_EDGE   = 3'd3;
    localparam t_op OP_QUERY_VERTEX  = 3'd4;
    localparam t_op OP_QUERY_EDGE    = 3'd5;

    // Status codes.
    localparam t_status ST_NO      = 2'd0;
    localparam t_status ST_OK      = 2'd1;
    localparam t_status ST_MISSING = 2'd2;
    localparam t_status ST_FULL    = 2'd3;

    // Outcome of one sweep over the slot table.
    typedef struct packed {
        logic  found_a;
        logic  found_b;
        logic  free_found;
        t_slot slot_a;
        t_slot slot_b;
        t_slot slot_free;
    } t_match;

endpackage

/* rtl/undirected_graph_store.sv */
// A request runs through S_SCAN and S_DECIDE. An accepted add or remove of a vertex
// then passes S_CLEAR, and an edge operation on two present vertices passes S_EDGE_A,
// where an accepted update writes row a and goes on to S_EDGE_B_RD and S_EDGE_B for
// row b; all end in S_DONE. The slot sweep and the row sweep take one slot per cycle
// each. One request is in work at a time; o_in_stall is high outside S_IDLE.
// Synchronous active-low reset clears only slot valid bits, control and match state.
module undirected_graph_store import ugs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_vertex_a,
    input  logic signed [31:0] i_vertex_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status
);

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_SCAN      = 8'b0000_0010,
        S_DECIDE    = 8'b0000_0100,
        S_EDGE_A    = 8'b0000_1000,
        S_EDGE_B_RD = 8'b0001_0000,
        S_EDGE_B    = 8'b0010_0000,
        S_CLEAR     = 8'b0100_0000,
        S_DONE      = 8'b1000_0000
    } t_state;

    t_state  r_state, n_state;
    t_op     r_op;
    t_label  r_va;
    t_label  r_vb;
    t_cnt    r_idx, n_idx;
    logic    r_rd_vld, n_rd_vld;
    t_slot   r_q_idx;
    t_label  r_lbl_q;
    logic    r_sv_q;
    t_row    r_row_q;
    t_slot   r_tgt, n_tgt;
    t_status r_status, n_status;
    t_row    r_slot_valid, n_slot_valid;
    logic    r_out_valid;
    t_status r_out_status;

    // Label store and adjacency rows. Both are read through a registered port.
    t_label  mem_label [MAX_VERTICES];
    t_row    mem_adj   [MAX_VERTICES];

    logic    start;
    logic    rd_go;
    t_slot   rd_addr;
    logic    lbl_we;
    logic    adj_we;
    t_slot   adj_wa;
    t_row    adj_wd;
    logic    out_load;
    logic    present;
    t_row    bit_a;
    t_row    bit_b;
    t_row    bit_tgt;
    t_match  match;

    // The shared compare unit: it sees one slot per cycle during the sweep.
    ugs_match u_match (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cmp_vld    (r_rd_vld && (r_state == S_SCAN)),
        .i_slot_valid (r_sv_q),
        .i_label      (r_lbl_q),
        .i_idx        (r_q_idx),
        .i_vertex_a   (r_va),
        .i_vertex_b   (r_vb),
        .o_match      (match)
    );

    assign bit_a   = t_row'(1) << match.slot_a;
    assign bit_b   = t_row'(1) << match.slot_b;
    assign bit_tgt = t_row'(1) << r_tgt;
    assign present = r_row_q[match.slot_b];

    // The sequencer. A sweep issues one read per cycle while the counter runs; the data
    // returns in the next cycle, so each sweep ends once the counter has reached the slot
    // count and the last read has drained.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_status     = r_status;
        n_slot_valid = r_slot_valid;
        start        = 1'b0;
        rd_go        = 1'b0;
        rd_addr      = r_idx[SLOT_W-1:0];
        lbl_we       = 1'b0;
        adj_we       = 1'b0;
        adj_wa       = r_q_idx;
        adj_wd       = r_row_q;
        out_load     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    start   = 1'b1;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_idx != SLOT_COUNT) begin
                    rd_go = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_idx   = '0;
                // Fetch the row of the first edge end in case an edge operation follows.
                rd_addr = match.slot_a;
                n_state = S_DONE;
                case (r_op)
                    OP_ADD_VERTEX: begin
                        if (match.found_a) begin
                            n_status = ST_NO;
                        end else if (!match.free_found) begin
                            n_status = ST_FULL;
                        end else begin
                            lbl_we                        = 1'b1;
                            n_slot_valid[match.slot_free] = 1'b1;
                            n_tgt                         = match.slot_free;
                            n_status                      = ST_OK;
                            n_state                       = S_CLEAR;
                        end
                    end
                    OP_REMOVE_VERTEX: begin
                        if (!match.found_a) begin
                            n_status = ST_NO;
                        end else begin
                            n_slot_valid[match.slot_a] = 1'b0;
                            n_tgt                      = match.slot_a;
                            n_status                   = ST_OK;
                            n_state                    = S_CLEAR;
                        end
                    end
                    OP_QUERY_VERTEX: begin
                        n_status = match.found_a ? ST_OK : ST_NO;
                    end
                    OP_ADD_EDGE, OP_REMOVE_EDGE, OP_QUERY_EDGE: begin
                        if (!match.found_a || !match.found_b) begin
                            n_status = ST_MISSING;
                        end else begin
                            n_state = S_EDGE_A;
                        end
                    end
                    default: begin
                        n_status = ST_NO;
                    end
                endcase
            end
            S_EDGE_A: begin
                // The matrix is kept symmetric, so row a alone tells whether the edge exists.
                adj_wa  = match.slot_a;
                n_state = S_DONE;
                case (r_op)
                    OP_ADD_EDGE: begin
                        if (present) begin
                            n_status = ST_NO;
                        end else begin
                            adj_we   = 1'b1;
                            adj_wd   = r_row_q | bit_b;
                            n_status = ST_OK;
                            n_state  = S_EDGE_B_RD;
                        end
                    end
                    OP_REMOVE_EDGE: begin
                        if (!present) begin
                            n_status = ST_NO;
                        end else begin
                            adj_we   = 1'b1;
                            adj_wd   = r_row_q & ~bit_b;
                            n_status = ST_OK;
                            n_state  = S_EDGE_B_RD;
                        end
                    end
                    default: begin
                        n_status = present ? ST_OK : ST_NO;
                    end
                endcase
            end
            S_EDGE_B_RD: begin
                // Row b is read only after row a has been written, which covers self-loops.
                rd_addr = match.slot_b;
                n_state = S_EDGE_B;
            end
            S_EDGE_B: begin
                adj_we  = 1'b1;
                adj_wa  = match.slot_b;
                adj_wd  = (r_op == OP_ADD_EDGE) ? (r_row_q | bit_a) : (r_row_q & ~bit_a);
                n_state = S_DONE;
            end
            S_CLEAR: begin
                // Each row is read and written back with the target's column bit cleared;
                // the target's own row is written as zero.
                if (r_idx != SLOT_COUNT) begin
                    rd_go = 1'b1;
                    n_idx = r_idx + 1'b1;
                end else if (!r_rd_vld) begin
                    n_state = S_DONE;
                end
                if (r_rd_vld) begin
                    adj_we = 1'b1;
                    adj_wa = r_q_idx;
                    adj_wd = (r_q_idx == r_tgt) ? '0 : (r_row_q & ~bit_tgt);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_rd_vld = rd_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_rd_vld     <= 1'b0;
            r_slot_valid <= '0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_vld     <= n_rd_vld;
            r_slot_valid <= n_slot_valid;
        end
    end

    // Request and working registers.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_op <= i_op;
            r_va <= i_vertex_a;
            r_vb <= i_vertex_b;
        end
        r_tgt    <= n_tgt;
        r_status <= n_status;
    end

    // Memories with one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (lbl_we) begin
            mem_label[match.slot_free] <= r_va;
        end
        if (adj_we) begin
            mem_adj[adj_wa] <= adj_wd;
        end
        r_lbl_q <= mem_label[rd_addr];
        r_row_q <= mem_adj[rd_addr];
        r_sv_q  <= r_slot_valid[rd_addr];
        r_q_idx <= rd_addr;
    end

    // Output register: the status waits here until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_status <= r_status;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    // A full table may only be reported when every slot is taken.
    a_full_means_all_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_FULL) |-> (&r_slot_valid))
        else $error("table full reported with a free slot");

    // A missing vertex is only ever reported for edge operations.
    a_missing_only_for_edges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_status == ST_MISSING) |->
        (r_op == OP_ADD_EDGE || r_op == OP_REMOVE_EDGE || r_op == OP_QUERY_EDGE))
        else $error("vertex missing reported for a vertex operation");

    // While the row and column are swept, the target slot is already allocated on an add.
    a_add_slot_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_op == OP_ADD_VERTEX) |-> r_slot_valid[r_tgt])
        else $error("slot sweep on add without the slot marked valid");

    // And already freed on a remove.
    a_remove_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && r_op == OP_REMOVE_VERTEX) |-> !r_slot_valid[r_tgt])
        else $error("slot sweep on remove with the slot still valid");
`endif

endmodule

/* rtl/ugs_match.sv */
module ugs_match import ugs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_cmp_vld,
    input  logic   i_slot_valid,
    input  t_label i_label,
    input  t_slot  i_idx,
    input  t_label i_vertex_a,
    input  t_label i_vertex_b,
    output t_match o_match
);

    t_match r_match;
    t_match n_match;

    // One slot is compared per cycle against both labels; the first free slot is kept.
    always_comb begin
        n_match = r_match;
        if (i_start) begin
            n_match = '0;
        end else if (i_cmp_vld) begin
            if (i_slot_valid && (i_label == i_vertex_a)) begin
                n_match.found_a = 1'b1;
                n_match.slot_a  = i_idx;
            end
            if (i_slot_valid && (i_label == i_vertex_b)) begin
                n_match.found_b = 1'b1;
                n_match.slot_b  = i_idx;
            end
            if (!i_slot_valid && !r_match.free_found) begin
                n_match.free_found = 1'b1;
                n_match.slot_free  = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_match = r_match;

endmodule

/* sim/graph_status_checker.sv */
module graph_status_checker import ugs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_stall,
    input  t_op    i_op,
    input  t_label i_vertex_a,
    input  t_label i_vertex_b,
    input  logic   i_out_valid,
    input  logic   i_out_stall,
    input  t_status i_status,
    output int     o_fail_count,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_op     op;
        t_label  a;
        t_label  b;
        t_status status;
    } t_request_due;

    // Shadow copy of the graph held by the block.
    logic   slot_used [MAX_VERTICES];
    t_label slot_name [MAX_VERTICES];
    t_row   links     [MAX_VERTICES];

    t_request_due status_due[$];
    t_request_due oldest;

    function automatic int slot_of(t_label label);
        int found;
        found = -1;
        for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
            if (slot_used[k] && slot_name[k] == label) begin
                found = k;
            end
        end
        return found;
    endfunction

    function automatic void clear_links(int s);
        for (int k = 0; k < MAX_VERTICES; k++) begin
            links[s][k] = 1'b0;
            links[k][s] = 1'b0;
        end
    endfunction

    // Applies one request to the shadow graph and returns the status it must give.
    function automatic t_status predict_status(t_op op, t_label a, t_label b);
        int      sa;
        int      sb;
        int      free_slot;
        logic    linked;
        t_status st;
        sa = slot_of(a);
        sb = slot_of(b);
        st = ST_NO;
        case (op)
            OP_ADD_VERTEX: begin
                free_slot = -1;
                for (int k = MAX_VERTICES - 1; k >= 0; k--) begin
                    if (!slot_used[k]) begin
                        free_slot = k;
                    end
                end
                if (sa >= 0) begin
                    st = ST_NO;
                end else if (free_slot < 0) begin
                    st = ST_FULL;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_name[free_slot] = a;
                    clear_links(free_slot);
                    st = ST_OK;
                end
            end
            OP_REMOVE_VERTEX: begin
                if (sa >= 0) begin
                    clear_links(sa);
                    slot_used[sa] = 1'b0;
                    st = ST_OK;
                end
            end
            OP_QUERY_VERTEX: begin
                st = (sa >= 0) ? ST_OK : ST_NO;
            end
            OP_ADD_EDGE, OP_REMOVE_EDGE, OP_QUERY_EDGE: begin
                if (sa < 0 || sb < 0) begin
                    st = ST_MISSING;
                end else begin
                    linked = links[sa][sb] && links[sb][sa];
                    if (op == OP_ADD_EDGE) begin
                        if (!linked) begin
                            links[sa][sb] = 1'b1;
                            links[sb][sa] = 1'b1;
                            st = ST_OK;
                        end
                    end else if (op == OP_REMOVE_EDGE) begin
                        if (linked) begin
                            links[sa][sb] = 1'b0;
                            links[sb][sa] = 1'b0;
                            st = ST_OK;
                        end
                    end else begin
                        st = linked ? ST_OK : ST_NO;
                    end
                end
            end
            default: begin
                st = ST_NO;
            end
        endcase
        return st;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int k = 0; k < MAX_VERTICES; k++) begin
            slot_used[k] = 1'b0;
            slot_name[k] = '0;
            links[k]     = '0;
        end
    end

    // The oldest request is retired before a new one is recorded, as a result can
    // never belong to a request accepted on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (status_due.size() == 0) begin
                    $display("%0t: status %0d arrived with no request outstanding",
                             $time, i_status);
                    o_fail_count++;
                end else begin
                    oldest = status_due.pop_front();
                    if (i_status !== oldest.status) begin
                        $display("%0t: op %0d a=%h b=%h: expected status %0d, got %0d",
                                 $time, oldest.op, oldest.a, oldest.b, oldest.status,
                                 i_status);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_due.push_back('{op: i_op, a: i_vertex_a, b: i_vertex_b,
                    status: predict_status(i_op, i_vertex_a, i_vertex_b)});
            end
            o_pending = status_due.size();
        end
    end

endmodule

/* sim/testbench.sv */
module testbench import ugs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // The op field is three bits wide, so the two codes beyond the six operations
    // must be exercised as well; the block answers them with a plain refusal.
    localparam t_op OP_SPARE_6 = 3'd6;
    localparam t_op OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1770;
    localparam int POOL_SIZE    = 24;
    // Longest latency of one request, with some margin, waited out at the end.
    localparam int TAIL_CYCLES  = 2 * MAX_VERTICES + 12;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_stall;
    t_op    i_op;
    t_label i_vertex_a;
    t_label i_vertex_b;
    logic   o_out_valid;
    logic   i_out_stall;
    t_status o_status;

    int     fail_count;
    int     pending;

    // When set, the sender offers every transfer back to back with no idle cycles.
    bit     sender_calm;

    // A small pool of labels keeps the random traffic hitting vertices that are
    // already present, so duplicates, full tables and real edges turn up often.
    t_label label_pool [POOL_SIZE];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    undirected_graph_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_vertex_a  (i_vertex_a),
        .i_vertex_b  (i_vertex_b),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status)
    );

    graph_status_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_vertex_a   (i_vertex_a),
        .i_vertex_b   (i_vertex_b),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Offers one request, starting and ending on a falling edge. Valid is only
    // lowered when an idle cycle is actually inserted, so a back-to-back transfer
    // never sees valid dropped and raised again within the same time step.
    task automatic offer_request(input t_op op, input t_label a, input t_label b);
        while (!sender_calm && $urandom_range(0, 99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_vertex_a <= a;
        i_vertex_b <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every outstanding status has been returned.
    task automatic await_quiet_graph();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (pending != 0);
    endtask

    function automatic t_label pick_label();
        if ($urandom_range(0, 9) == 0) begin
            return t_label'($urandom);
        end
        return label_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // While the graph is growing, adds dominate so that the slot table fills up;
    // while it is shrinking, removals dominate so that slots are freed and reused.
    function automatic t_op pick_op(bit growing);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 40 : 10)) begin
            return OP_ADD_VERTEX;
        end else if (roll < 45) begin
            return OP_REMOVE_VERTEX;
        end else if (roll < 63) begin
            return OP_ADD_EDGE;
        end else if (roll < 75) begin
            return OP_REMOVE_EDGE;
        end else if (roll < 84) begin
            return OP_QUERY_VERTEX;
        end else if (roll < 95) begin
            return OP_QUERY_EDGE;
        end
        return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
    endfunction

    // Receiver: stalls at random, but holds off for one long stretch early on so
    // that the block backs up and stalls its own input, and later stays ready for
    // a long stretch.
    initial begin
        int cycle_count;
        cycle_count = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count >= 3000 && cycle_count < 3400) begin
                i_out_stall <= 1'b1;
            end else if (cycle_count >= 18000 && cycle_count < 30000) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 36);
            end
        end
    end

    // Guard against a hung block: far beyond the slowest legal run.
    initial begin
        #8_000_000;
        $display("undirected_graph_store verification failed");
        $finish;
    end

    initial begin
        t_op    op;
        t_label a;
        t_label b;
        bit     growing;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_op        = OP_QUERY_VERTEX;
        i_vertex_a  = '0;
        i_vertex_b  = '0;
        sender_calm = 1'b0;
        growing     = 1'b1;

        label_pool[0] = 32'h0000_0000;
        label_pool[1] = 32'hFFFF_FFFF;
        label_pool[2] = 32'h7FFF_FFFF;
        label_pool[3] = 32'h8000_0000;
        for (int k = 4; k < POOL_SIZE; k++) begin
            label_pool[k] = t_label'($urandom);
        end

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Label zero is an ordinary label and is used first, on
        // an empty graph, so that any leftover treatment of it as absent shows up.
        offer_request(OP_QUERY_VERTEX, 32'h0000_0000, t_label'($urandom));
        offer_request(OP_ADD_EDGE, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_ADD_VERTEX, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_ADD_VERTEX, 32'h0000_0000, 32'h0000_0000);
        // A self-loop is a legal edge.
        offer_request(OP_ADD_EDGE, 32'h0000_0000, 32'h0000_0000);
        offer_request(OP_ADD_VERTEX, 32'hFFFF_FFFF, t_label'($urandom));
        offer_request(OP_ADD_EDGE, 32'hFFFF_FFFF, 32'h0000_0000);
        // The same edge named the other way round is a duplicate.
        offer_request(OP_ADD_EDGE, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_QUERY_EDGE, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_request(OP_REMOVE_EDGE, 32'h0000_0000, 32'h8000_0000);
        offer_request(OP_REMOVE_EDGE, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_request(OP_REMOVE_EDGE, 32'hFFFF_FFFF, 32'h0000_0000);
        // Removing a vertex that still has a self-loop must clear it.
        offer_request(OP_REMOVE_VERTEX, 32'h0000_0000, t_label'($urandom));
        offer_request(OP_REMOVE_VERTEX, 32'h0000_0000, t_label'($urandom));
        offer_request(OP_SPARE_6, 32'h7FFF_FFFF, 32'h8000_0000);
        offer_request(OP_SPARE_7, 32'h8000_0000, 32'h7FFF_FFFF);

        // Fill the table: label zero comes back into a slot whose links were
        // cleared, then the adds beyond the slot count must report the table as full.
        offer_request(OP_ADD_VERTEX, label_pool[0], t_label'($urandom));
        offer_request(OP_QUERY_EDGE, label_pool[0], label_pool[0]);
        for (int k = 2; k < MAX_VERTICES + 1; k++) begin
            offer_request(OP_ADD_VERTEX, label_pool[k], t_label'($urandom));
        end
        offer_request(OP_ADD_VERTEX, label_pool[MAX_VERTICES + 1], t_label'($urandom));
        await_quiet_graph();

        // Random traffic, alternating between growing and shrinking the graph.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                growing = !growing;
            end
            sender_calm = (n >= 700 && n < 1000);
            if (n == 400 || n == 1300) begin
                await_quiet_graph();
            end
            op = pick_op(growing);
            a  = pick_label();
            if (op == OP_ADD_EDGE || op == OP_REMOVE_EDGE || op == OP_QUERY_EDGE) begin
                b = ($urandom_range(0, 9) == 0) ? a : pick_label();
            end else begin
                b = t_label'($urandom);
            end
            offer_request(op, a, b);
        end

        await_quiet_graph();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("undirected_graph_store verification clean");
        end else begin
            $display("undirected_graph_store verification failed");
        end
        $finish;
    end

endmodule
